// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, off while reset is held
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// same check, but also evaluated while reset is held
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// Types and constants of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int DIV_BITS = 64;
    localparam int CNT_BITS = $clog2(DIV_BITS);

    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIVI = 3'd3;
    localparam logic [2:0] OP_ADDI = 3'd4;
    localparam logic [2:0] OP_MULI = 3'd5;
    localparam logic [2:0] OP_CMP  = 3'd6;
    localparam logic [2:0] OP_NONE = 3'd7;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_ZDIV = 2'd2;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } req_t;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic signed [31:0] res_den;
        logic [1:0]         status;
    } res_t;

    typedef struct packed {
        logic                start;
        logic [DIV_BITS-1:0] dividend;
        logic [DIV_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [DIV_BITS-1:0] quot;
        logic [DIV_BITS-1:0] rem;
    } div_rsp_t;

    typedef enum logic [4:0] {
        S_IDLE, S_GCD, S_GCDW, S_QA, S_QAW, S_QB, S_QBW,
        S_MUL1, S_MUL2, S_MUL3, S_COMB, S_RN, S_RNW, S_RD, S_RDW, S_CHK
    } state_t;

    function automatic logic [31:0] mag32(logic signed [31:0] x);
        return x[31] ? 32'(-x) : 32'(x);
    endfunction

    // magnitude and sign back to a wide signed value
    function automatic logic signed [65:0] to_s66(logic [63:0] m, logic neg);
        logic signed [65:0] v;
        v = signed'({2'b00, m});
        return neg ? -v : v;
    endfunction

endpackage

// ===== src/rational_arith_unit.sv =====
// ----------------------------------------------------------------------------
// rational_arith_unit
// Fraction add, subtract, multiply and compare, integer add, multiply and divide,
// gcd reduction (not compare/integer add), one iterative divider, 32x32 multiplier.
// ----------------------------------------------------------------------------
//  channel   ports                      payload
//  input     s_valid s_ready s_data     req_t (req_type, a/b num, den)
//  result    m_valid m_ready m_data     res_t (res_num, res_den, status)
//
//  each remainder step of a gcd and each quotient is one run of the
//  shared 64-bit divider; an add or subtract runs one gcd plus two quotients,
//  then reduces with a second gcd plus two quotients. compare runs the first
//  gcd and quotients but skips the reduction. multiply, divide by integer and
//  multiply by integer run one gcd plus two quotients; add integer uses no
//  divider. op 7 and zero divisors go straight to the result.
//  one item at a time; s_ready is high only in idle. a waiting result is
//  held in the output register and the next item may be taken meanwhile;
//  a finished item waits in its last state while that register is full.
//  reset is synchronous, active low.
// ----------------------------------------------------------------------------
module rational_arith_unit import rau_pkg::*; #(
    parameter int WORD_BITS = 32
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output res_t m_data
);

    localparam int EFF_BITS = (WORD_BITS > 32) ? 32 : ((WORD_BITS < 2) ? 2 : WORD_BITS);
    localparam logic signed [65:0] LIM_HI = (66'sd1 <<< (EFF_BITS - 1)) - 66'sd1;
    localparam logic signed [65:0] LIM_LO = -(66'sd1 <<< (EFF_BITS - 1));

    state_t state_reg, state_next;

    logic [2:0]  op_reg;
    logic        sa_reg, sad_reg, sbn_reg, sbd_reg;
    logic [31:0] ma_reg, mad_reg, mbn_reg, mbd_reg;
    logic [31:0] qa_reg, qb_reg;
    logic [63:0] gx_reg, gy_reg;
    logic [63:0] nmag_reg, dmag_reg;
    logic        nsgn_reg, dsgn_reg;
    logic        red_reg;
    logic [63:0] p_reg;
    logic signed [65:0] t1_reg;
    logic signed [65:0] rn_reg, rd_reg;
    logic [1:0]  st_reg;
    logic        m_valid_reg;
    res_t        m_data_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;
    logic [31:0] mul_a, mul_b;
    logic signed [65:0] t2_v, sum_v;
    logic        zero_v, out_free, fits_v;

    rau_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign zero_v = (s_data.a_den == 32'sd0)
                 || ((s_data.req_type == OP_ADD || s_data.req_type == OP_SUB
                      || s_data.req_type == OP_MUL || s_data.req_type == OP_CMP)
                     && s_data.b_den == 32'sd0)
                 || (s_data.req_type == OP_DIVI && s_data.b_num == 32'sd0);
    assign out_free = !m_valid_reg || m_ready;
    assign fits_v   = rn_reg >= LIM_LO && rn_reg <= LIM_HI
                   && rd_reg >= LIM_LO && rd_reg <= LIM_HI;

    always_comb begin
        t2_v  = to_s66(p_reg, sbn_reg ^ sbd_reg);
        sum_v = (op_reg == OP_ADD) ? t1_reg + t2_v : t1_reg - t2_v;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next       = state_reg;
        div_req.start    = 1'b0;
        div_req.dividend = gx_reg;
        div_req.divisor  = gy_reg;
        mul_a            = '0;
        mul_b            = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_data.req_type == OP_NONE || zero_v) begin
                        state_next = S_CHK;
                    end else if (s_data.req_type == OP_ADD || s_data.req_type == OP_SUB
                                 || s_data.req_type == OP_CMP) begin
                        state_next = S_GCD;
                    end else begin
                        state_next = S_MUL1;
                    end
                end
            end
            S_GCD: begin
                if (gy_reg == '0) begin
                    state_next = red_reg ? S_RN : S_QA;
                end else begin
                    div_req.start = 1'b1;
                    state_next    = S_GCDW;
                end
            end
            S_GCDW: if (div_rsp.done) state_next = S_GCD;
            S_QA: begin
                div_req.start    = 1'b1;
                div_req.dividend = {32'b0, mbd_reg};
                div_req.divisor  = gx_reg;
                state_next       = S_QAW;
            end
            S_QAW: if (div_rsp.done) state_next = S_QB;
            S_QB: begin
                div_req.start    = 1'b1;
                div_req.dividend = {32'b0, mad_reg};
                div_req.divisor  = gx_reg;
                state_next       = S_QBW;
            end
            S_QBW: if (div_rsp.done) state_next = S_MUL1;
            S_MUL1: begin
                case (op_reg)
                    OP_ADD, OP_SUB, OP_CMP: begin
                        mul_a = ma_reg;
                        mul_b = qa_reg;
                    end
                    OP_MUL, OP_MULI: begin
                        mul_a = ma_reg;
                        mul_b = mbn_reg;
                    end
                    default: begin
                        mul_a = mad_reg;
                        mul_b = mbn_reg;
                    end
                endcase
                state_next = (op_reg == OP_ADD || op_reg == OP_SUB || op_reg == OP_CMP
                              || op_reg == OP_MUL) ? S_MUL2 : S_COMB;
            end
            S_MUL2: begin
                if (op_reg == OP_MUL) begin
                    mul_a      = mad_reg;
                    mul_b      = mbd_reg;
                    state_next = S_COMB;
                end else begin
                    mul_a      = mbn_reg;
                    mul_b      = qb_reg;
                    state_next = S_MUL3;
                end
            end
            S_MUL3: begin
                mul_a      = qb_reg;
                mul_b      = mbd_reg;
                state_next = (op_reg == OP_CMP) ? S_CHK : S_COMB;
            end
            S_COMB: state_next = (op_reg == OP_ADDI) ? S_CHK : S_GCD;
            S_RN: begin
                div_req.start    = 1'b1;
                div_req.dividend = nmag_reg;
                div_req.divisor  = gx_reg;
                state_next       = S_RNW;
            end
            S_RNW: if (div_rsp.done) state_next = S_RD;
            S_RD: begin
                div_req.start    = 1'b1;
                div_req.dividend = dmag_reg;
                div_req.divisor  = gx_reg;
                state_next       = S_RDW;
            end
            S_RDW: if (div_rsp.done) state_next = S_CHK;
            S_CHK: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath, one product registered per cycle
    always_ff @(posedge aclk) begin
        p_reg <= 64'(mul_a) * 64'(mul_b);
        case (state_reg)
            S_IDLE: begin
                op_reg  <= s_data.req_type;
                sa_reg  <= s_data.a_num[31];
                sad_reg <= s_data.a_den[31];
                sbn_reg <= s_data.b_num[31];
                sbd_reg <= s_data.b_den[31];
                ma_reg  <= mag32(s_data.a_num);
                mad_reg <= mag32(s_data.a_den);
                mbn_reg <= mag32(s_data.b_num);
                mbd_reg <= mag32(s_data.b_den);
                gx_reg  <= {32'b0, mag32(s_data.a_den)};
                gy_reg  <= {32'b0, mag32(s_data.b_den)};
                red_reg <= 1'b0;
                st_reg  <= (zero_v && s_data.req_type != OP_NONE) ? ST_ZDIV : ST_OK;
                rn_reg  <= '0;
                rd_reg  <= (zero_v && s_data.req_type != OP_NONE) ? 66'sd0 : 66'sd1;
            end
            S_GCDW: begin
                if (div_rsp.done) begin
                    gx_reg <= gy_reg;
                    gy_reg <= div_rsp.rem;
                end
            end
            S_QAW: if (div_rsp.done) qa_reg <= div_rsp.quot[31:0];
            S_QBW: if (div_rsp.done) qb_reg <= div_rsp.quot[31:0];
            S_MUL2: begin
                if (op_reg == OP_MUL) begin
                    nmag_reg <= p_reg;
                    nsgn_reg <= sa_reg ^ sbn_reg;
                end else begin
                    t1_reg <= to_s66(p_reg, sa_reg ^ sad_reg);
                end
            end
            S_MUL3: begin
                if (op_reg == OP_CMP) begin
                    rn_reg <= sum_v;
                    rd_reg <= 66'sd1;
                end else begin
                    nmag_reg <= sum_v[65] ? 64'(-sum_v) : sum_v[63:0];
                    nsgn_reg <= sum_v[65];
                end
            end
            S_COMB: begin
                red_reg <= 1'b1;
                case (op_reg)
                    OP_DIVI: begin
                        nmag_reg <= {32'b0, ma_reg};
                        nsgn_reg <= sa_reg;
                        dmag_reg <= p_reg;
                        dsgn_reg <= sad_reg ^ sbn_reg;
                        gx_reg   <= {32'b0, ma_reg};
                        gy_reg   <= p_reg;
                    end
                    OP_MULI: begin
                        nmag_reg <= p_reg;
                        nsgn_reg <= sa_reg ^ sbn_reg;
                        dmag_reg <= {32'b0, mad_reg};
                        dsgn_reg <= sad_reg;
                        gx_reg   <= p_reg;
                        gy_reg   <= {32'b0, mad_reg};
                    end
                    OP_ADDI: begin
                        rn_reg <= to_s66({32'b0, ma_reg}, sa_reg)
                                + to_s66(p_reg, sbn_reg ^ sad_reg);
                        rd_reg <= to_s66({32'b0, mad_reg}, sad_reg);
                    end
                    default: begin
                        // add, subtract and multiply: denominator from last product
                        dmag_reg <= p_reg;
                        dsgn_reg <= (op_reg == OP_MUL) ? (sad_reg ^ sbd_reg) : 1'b0;
                        gx_reg   <= nmag_reg;
                        gy_reg   <= p_reg;
                    end
                endcase
            end
            S_RNW: if (div_rsp.done) nmag_reg <= div_rsp.quot;
            S_RDW: begin
                if (div_rsp.done) begin
                    rn_reg <= to_s66(nmag_reg, nsgn_reg ^ dsgn_reg);
                    rd_reg <= to_s66(div_rsp.quot, 1'b0);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == S_CHK && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_CHK && out_free) begin
            if (st_reg == ST_OK && !fits_v) begin
                m_data_reg.res_num <= '0;
                m_data_reg.res_den <= '0;
                m_data_reg.status  <= ST_OVF;
            end else begin
                m_data_reg.res_num <= rn_reg[31:0];
                m_data_reg.res_den <= rd_reg[31:0];
                m_data_reg.status  <= st_reg;
            end
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== src/rau_div.sv =====
// ----------------------------------------------------------------------------
// rau_div
// Restoring radix-2 divider, one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
module rau_div import rau_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [DIV_BITS:0]   rem_reg;
    logic [DIV_BITS-1:0] quo_reg;
    logic [DIV_BITS-1:0] dvs_reg;

    logic [DIV_BITS:0]   shift_v;
    logic [DIV_BITS+1:0] diff_v;
    logic                ge_v;
    logic [DIV_BITS:0]   rem_next;
    logic [DIV_BITS-1:0] quo_next;

    always_comb begin
        shift_v  = {rem_reg[DIV_BITS-1:0], quo_reg[DIV_BITS-1]};
        diff_v   = {1'b0, shift_v} - {2'b00, dvs_reg};
        ge_v     = !diff_v[DIV_BITS+1];
        rem_next = ge_v ? diff_v[DIV_BITS:0] : shift_v;
        quo_next = {quo_reg[DIV_BITS-2:0], ge_v};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(DIV_BITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg[DIV_BITS-1:0];

endmodule

// ===== src/rau_checker.sv =====
// ----------------------------------------------------------------------------
// rau_checker
// Port-level checks of the rational arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rau_checker import rau_pkg::*; (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input req_t s_data,
    input logic m_valid,
    input logic m_ready,
    input res_t m_data
);

    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "result changed while stalled")
    `ASSERT_CLK(a_busy_after_in, aclk, aresetn, s_valid && s_ready |=> !s_ready, "ready stayed high after an input transfer")
    `ASSERT_CLK(a_zdiv_zero, aclk, aresetn, m_valid && m_data.status == ST_ZDIV |-> m_data.res_num == 0 && m_data.res_den == 0, "zero divisor result not cleared")
    `ASSERT_CLK(a_ovf_zero, aclk, aresetn, m_valid && m_data.status == ST_OVF |-> m_data.res_num == 0 && m_data.res_den == 0, "overflow result not cleared")
    `ASSERT_CLK(a_ok_den, aclk, aresetn, m_valid && m_data.status == ST_OK |-> m_data.res_den != 0, "good result with zero denominator")

endmodule

bind rational_arith_unit rau_checker u_rau_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== tb/rational_arith_unit_tb.sv =====
// ----------------------------------------------------------------------------
// rational_arith_unit_tb
// Self-checking bench for the rational arithmetic unit: a directed table of
// corner requests, then random fraction requests under three sender/receiver
// stall mixes; results go against typed rows or a 66-bit fraction calculator.
// ----------------------------------------------------------------------------
module rational_arith_unit_tb;
    import rau_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  N_RANDOM    = 1130;
    localparam longint LIMIT    = 60_000_000;
    localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] S_MAX = 32'sh7fff_ffff;

    typedef logic signed [65:0] wide_t;

    typedef struct {
        req_t req;
        bit   typed;
        res_t res;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    res_t m_data;

    res_t   pending_q[$];
    int     n_errors = 0;
    int     n_results = 0;
    int     n_sent = 0;
    int     n_status[4] = '{0, 0, 0, 0};
    longint n_cycles = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;

    rational_arith_unit i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        n_cycles++;
        if (n_cycles > LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", n_cycles,
                     pending_q.size());
            $display("rational_arith_unit: mismatch");
            $finish;
        end
    end

    function automatic wide_t mag(wide_t x);
        return x < 0 ? -x : x;
    endfunction

    function automatic wide_t gcd_of(wide_t x, wide_t y);
        wide_t r;
        while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    function automatic bit fits32(wide_t x);
        return x >= -(66'sd1 <<< 31) && x <= (66'sd1 <<< 31) - 1;
    endfunction

    function automatic res_t reduced_fraction(wide_t n, wide_t d);
        wide_t g;
        res_t  r;
        g = gcd_of(mag(n), mag(d));
        n = n / g;
        d = d / g;
        if (d < 0) begin
            n = -n;
            d = -d;
        end
        r.res_num = n[31:0];
        r.res_den = d[31:0];
        r.status  = (fits32(n) && fits32(d)) ? ST_OK : ST_OVF;
        if (r.status != ST_OK) begin
            r.res_num = '0;
            r.res_den = '0;
        end
        return r;
    endfunction

    function automatic res_t predict_fraction(req_t q);
        wide_t an, ad, bn, bd, g, qa, qb, n, d;
        res_t  r;
        an = q.a_num;
        ad = q.a_den;
        bn = q.b_num;
        bd = q.b_den;
        r.res_num = '0;
        r.res_den = '0;
        r.status  = ST_ZDIV;
        if (q.req_type == OP_NONE) begin
            r.res_den = 32'sd1;
            r.status  = ST_OK;
            return r;
        end
        if (ad == 0 || (q.req_type inside {OP_ADD, OP_SUB, OP_MUL, OP_CMP} && bd == 0)
            || (q.req_type == OP_DIVI && bn == 0))
            return r;
        case (q.req_type)
            OP_ADD, OP_SUB, OP_CMP: begin
                g  = gcd_of(mag(ad), mag(bd));
                qa = mag(bd) / g;
                qb = mag(ad) / g;
                if (ad < 0) qa = -qa;
                if (bd < 0) qb = -qb;
                if (q.req_type == OP_CMP) begin
                    n = an * qa - bn * qb;
                    d = 1;
                end else begin
                    n = (q.req_type == OP_ADD) ? an * qa + bn * qb : an * qa - bn * qb;
                    return reduced_fraction(n, mag(ad) / g * mag(bd));
                end
            end
            OP_MUL:  return reduced_fraction(an * bn, ad * bd);
            OP_DIVI: return reduced_fraction(an, ad * bn);
            OP_ADDI: begin
                n = an + bn * ad;
                d = ad;
            end
            default: return reduced_fraction(an * bn, ad);
        endcase
        if (fits32(n) && fits32(d)) begin
            r.res_num = n[31:0];
            r.res_den = d[31:0];
            r.status  = ST_OK;
        end else begin
            r.status = ST_OVF;
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        n_errors++;
        $display("%0t: result %0d field %s got %0h want %0h", $realtime, n_results, field,
                 got, want);
    endtask

    // result side: compare every transfer with the oldest prediction
    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected", m_data.res_num, '0);
            end else begin
                want = pending_q.pop_front();
                if (m_data.res_num !== want.res_num)
                    report_mismatch("res_num", m_data.res_num, want.res_num);
                if (m_data.res_den !== want.res_den)
                    report_mismatch("res_den", m_data.res_den, want.res_den);
                if (m_data.status !== want.status)
                    report_mismatch("status", 32'(m_data.status), 32'(want.status));
                n_status[want.status]++;
            end
            n_results++;
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_request(req_t q, bit typed, res_t typed_res);
        res_t want;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= q;
        do @(posedge aclk); while (!s_ready);
        want = predict_fraction(q);
        if (typed && want !== typed_res)
            $display("table row %0d disagrees with calculator", n_sent);
        pending_q.push_back(typed ? typed_res : want);
        n_sent++;
        @(negedge aclk);
    endtask

    function automatic logic signed [31:0] pick_value(bit nonzero);
        logic signed [31:0] v;
        case ($urandom_range(9))
            0, 1, 2, 3: v = $urandom_range(0, 40) - 20;
            4, 5:       v = $urandom_range(0, 4000) - 2000;
            6:          v = $urandom_range(0, 2) == 0 ? S_MIN :
                            ($urandom_range(1) ? S_MAX : 32'sd0);
            default:    v = $urandom;
        endcase
        if (nonzero && v == 0) v = 32'sd1;
        return v;
    endfunction

    function automatic req_t random_request();
        req_t q;
        int   pick;
        pick = $urandom_range(99);
        q.req_type = (pick < 3) ? OP_NONE : 3'($urandom_range(6));
        // mostly well-formed, a few zero divisors from the raw picks
        q.a_num = pick_value(1'b0);
        q.a_den = pick_value($urandom_range(19) != 0);
        q.b_num = pick_value(q.req_type == OP_DIVI && $urandom_range(19) != 0);
        q.b_den = pick_value($urandom_range(19) != 0);
        return q;
    endfunction

    function automatic row_t mk(logic [2:0] op, int an, int ad, int bn, int bd, bit typed = 0,
                                int rn = 0, int rd = 0, logic [1:0] st = ST_OK);
        row_t r;
        r.req   = '{op, an, ad, bn, bd};
        r.typed = typed;
        r.res   = '{rn, rd, st};
        return r;
    endfunction

    initial begin
        row_t  stim_table[$];
        req_t  q;
        int    phase;

        stim_table = '{
            mk(OP_NONE, 5, 7, 9, 11, 1, 0, 1, ST_OK),
            mk(OP_ADD, 1, 0, 1, 2, 1, 0, 0, ST_ZDIV),
            mk(OP_SUB, 1, 2, 1, 0, 1, 0, 0, ST_ZDIV),
            mk(OP_MUL, S_MAX, 1, 3, 0, 1, 0, 0, ST_ZDIV),
            mk(OP_DIVI, 3, 4, 0, 9, 1, 0, 0, ST_ZDIV),
            mk(OP_CMP, 1, 3, 1, 0, 1, 0, 0, ST_ZDIV),
            mk(OP_ADDI, 1, 0, 2, 0, 1, 0, 0, ST_ZDIV),
            mk(OP_ADD, 1, 2, 1, 3, 1, 5, 6, ST_OK),
            mk(OP_SUB, 1, 2, 1, 3, 1, 1, 6, ST_OK),
            mk(OP_MUL, 2, 3, 3, 4, 1, 1, 2, ST_OK),
            mk(OP_DIVI, 2, 3, 4, 1, 1, 1, 6, ST_OK),
            mk(OP_ADDI, 2, 4, 1, 0, 1, 6, 4, ST_OK),
            mk(OP_MULI, 2, 4, 3, 0, 1, 3, 2, ST_OK),
            mk(OP_CMP, 1, 2, 1, 3, 1, 1, 1, ST_OK),
            mk(OP_ADD, 1, -2, 0, 1, 1, -1, 2, ST_OK),
            mk(OP_SUB, 3, 5, 3, 5, 1, 0, 1, ST_OK),
            mk(OP_MUL, S_MAX, 1, S_MAX, 1, 1, 0, 0, ST_OVF),
            mk(OP_MULI, S_MIN, -1, 1, 7, 1, 0, 0, ST_OVF),
            mk(OP_DIVI, S_MIN, 1, -1, 0, 1, 0, 0, ST_OVF),
            mk(OP_ADDI, S_MIN, S_MIN, S_MIN, S_MIN),
            mk(OP_ADD, S_MAX, S_MAX - 1, S_MIN, S_MAX),
            mk(OP_SUB, S_MAX, S_MIN, S_MIN, S_MAX),
            mk(OP_CMP, S_MIN, 1, S_MAX, 1),
            mk(OP_CMP, S_MIN, S_MAX, S_MAX, S_MIN),
            mk(OP_MUL, -6, -4, 10, -15)
        };

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (stim_table[i])
            send_request(stim_table[i].req, stim_table[i].typed, stim_table[i].res);

        // hold off until the unit has drained
        s_valid <= 1'b0;
        wait (pending_q.size() == 0);
        @(negedge aclk);

        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 76 : 0;
            recv_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 24 : 0;
            repeat (N_RANDOM / 3) begin
                q = random_request();
                send_request(q, 1'b0, '0);
            end
        end
        s_valid <= 1'b0;

        wait (pending_q.size() == 0);
        repeat (200) @(posedge aclk);

        $display("%0d requests sent, %0d results: %0d ok, %0d overflow, %0d zero divisor",
                 n_sent, n_results, n_status[ST_OK], n_status[ST_OVF], n_status[ST_ZDIV]);
        $display("all seven operations plus the unused code, under three stall mixes");
        if (n_errors == 0) begin
            $display("rational_arith_unit: match");
        end else begin
            $display("%0d field errors", n_errors);
            $display("rational_arith_unit: mismatch");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/rau_pkg.sv
src/rau_div.sv
src/rational_arith_unit.sv
src/rau_checker.sv
tb/rational_arith_unit_tb.sv
